/* hdl/trtbm_pkg.sv */
// Shared widths, register indexes, color codes and types for the two-rate token bucket meter.
package trtbm_pkg;

  // Field and state widths
  localparam int TS_W       = 48;
  localparam int LEN_W      = 16;
  localparam int RATE_W     = 32;
  localparam int TOK_W      = 32;
  localparam int EARN_W     = 64;
  localparam int COLOR_W    = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Fraction bits of the rate (0..32)
  localparam int RATE_FRAC_BITS = 16;

  // Partial product widths of timestamp * rate
  localparam int TS_LO_W   = 32;
  localparam int TS_HI_W   = TS_W - TS_LO_W;
  localparam int PLO_W     = TS_LO_W + RATE_W;
  localparam int PHI_W     = TS_HI_W + RATE_W;
  localparam int PROD_W    = EARN_W + 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_METER_ENABLE      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_METER_MODE        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_INFO_RATE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FIRST_BURST_SIZE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_INFO_RATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SECOND_BURST_SIZE = 3'd5;

  // Result colors
  localparam logic [COLOR_W-1:0] COLOR_CONFORM     = 2'd0;
  localparam logic [COLOR_W-1:0] COLOR_EXCEED_FIRST  = 2'd1;
  localparam logic [COLOR_W-1:0] COLOR_EXCEED_SECOND = 2'd2;

  // Cost of one packet in packet mode
  localparam logic [LEN_W-1:0] PACKET_COST = 16'd1;

  // Per-bucket control from the top level
  typedef struct packed {
    logic check;   // apply one packet to the bucket
    logic refill;  // burst register write
  } bucket_ctl_t;

endpackage

/* hdl/trtbm_in_if.sv */
// Input channel: packet timestamp and length with valid/ready handshake.
interface trtbm_in_if;
  logic                          valid;
  logic                          ready;
  logic [trtbm_pkg::TS_W-1:0]    timestamp;
  logic [trtbm_pkg::LEN_W-1:0]   packet_length;

  modport source (output valid, output timestamp, output packet_length, input ready);
  modport sink   (input valid, input timestamp, input packet_length, output ready);
endinterface

/* hdl/trtbm_out_if.sv */
// Result channel: meter color with valid/ready handshake.
interface trtbm_out_if;
  logic                            valid;
  logic                            ready;
  logic [trtbm_pkg::COLOR_W-1:0]   color;

  modport source (output valid, output color, input ready);
  modport sink   (input valid, input color, output ready);
endinterface

/* hdl/trtbm_bucket.sv */
// One token bucket: token count and earned total, refill on burst write, check per packet.
module trtbm_bucket (
  input  logic                             clk,
  input  logic                             rst_n,
  input  trtbm_pkg::bucket_ctl_t           ctl,
  input  logic [trtbm_pkg::TOK_W-1:0]      burst,
  input  logic [trtbm_pkg::TOK_W-1:0]      refill_value,
  input  logic [trtbm_pkg::EARN_W-1:0]     now_earned,
  input  logic [trtbm_pkg::LEN_W-1:0]      cost,
  output logic                             pass
);

  logic [trtbm_pkg::TOK_W-1:0]  tokens_r, tokens_nxt;
  logic [trtbm_pkg::EARN_W-1:0] earned_r, earned_nxt;
  logic [trtbm_pkg::EARN_W-1:0] gain;
  logic                         forward;
  logic [trtbm_pkg::TOK_W:0]    sum;
  logic [trtbm_pkg::TOK_W-1:0]  capped;
  logic [trtbm_pkg::TOK_W-1:0]  cost_w;

  // Earn tokens since the last check; time going backwards earns nothing
  always_comb begin
    forward    = (now_earned >= earned_r);
    gain       = forward ? (now_earned - earned_r) : '0;
    earned_nxt = forward ? now_earned : earned_r;
  end

  // Add the gain and cap at the burst size
  always_comb begin
    sum = {1'b0, tokens_r} + {1'b0, gain[trtbm_pkg::TOK_W-1:0]};
    if (gain >= {{(trtbm_pkg::EARN_W-trtbm_pkg::TOK_W){1'b0}}, burst}) begin
      capped = burst;
    end else if (sum > {1'b0, burst}) begin
      capped = burst;
    end else begin
      capped = sum[trtbm_pkg::TOK_W-1:0];
    end
  end

  // Take the cost if the bucket holds enough
  always_comb begin
    cost_w     = {{(trtbm_pkg::TOK_W-trtbm_pkg::LEN_W){1'b0}}, cost};
    pass       = (capped >= cost_w);
    tokens_nxt = pass ? (capped - cost_w) : capped;
  end

  // Hold bucket state; refill on burst write, advance on check
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tokens_r <= '0;
      earned_r <= '0;
    end else if (ctl.refill) begin
      tokens_r <= refill_value;
      earned_r <= '0;
    end else if (ctl.check) begin
      tokens_r <= tokens_nxt;
      earned_r <= earned_nxt;
    end
  end

endmodule

/* hdl/two_rate_token_bucket_meter_core.sv */
// Path: an accepted input beat passes through the input, product, earned total and result
// registers before its result beat.
// Throughput: one packet per cycle unless the result channel stalls; the bucket state closes its
// loop in the last stage, which takes one packet per cycle, and each stage moves as soon as the one ahead frees.
// Reset (synchronous, rst_n low): configuration registers, token counts and earned totals
// clear to zero, pipeline empty; the meter starts disabled.
module two_rate_token_bucket_meter_core (
  input  logic                                clk,
  input  logic                                rst_n,
  trtbm_in_if.sink                            in_ch,
  trtbm_out_if.source                         out_ch,
  input  logic                                cfg_we,
  input  logic [trtbm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [trtbm_pkg::CFG_DATA_W-1:0]    cfg_data
);

  // Configuration registers
  logic                          meter_enable_r;
  logic                          meter_mode_r;
  logic [trtbm_pkg::RATE_W-1:0]  first_rate_r;
  logic [trtbm_pkg::TOK_W-1:0]   first_burst_r;
  logic [trtbm_pkg::RATE_W-1:0]  second_rate_r;
  logic [trtbm_pkg::TOK_W-1:0]   second_burst_r;

  // Pipeline registers
  logic                          v1_r, v2_r, v3_r, out_valid_r;
  logic [trtbm_pkg::TS_W-1:0]    ts1_r;
  logic [trtbm_pkg::LEN_W-1:0]   len1_r, len2_r, len3_r;
  logic [trtbm_pkg::PLO_W-1:0]   p1lo_r, p2lo_r;
  logic [trtbm_pkg::PHI_W-1:0]   p1hi_r, p2hi_r;
  logic [trtbm_pkg::EARN_W-1:0]  earn1_r, earn2_r;
  logic [trtbm_pkg::COLOR_W-1:0] color_r, color_nxt;

  logic                          rdy_out, rdy3, rdy2, rdy1;
  logic                          move3;
  logic [trtbm_pkg::PROD_W-1:0]  full1, full2;
  logic [trtbm_pkg::LEN_W-1:0]   cost3;
  logic                          pass1, pass2;
  trtbm_pkg::bucket_ctl_t        ctl1, ctl2;

  // Write configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      meter_enable_r <= 1'b0;
      meter_mode_r   <= 1'b0;
      first_rate_r   <= '0;
      first_burst_r  <= '0;
      second_rate_r  <= '0;
      second_burst_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        trtbm_pkg::REG_METER_ENABLE:      meter_enable_r <= cfg_data[0];
        trtbm_pkg::REG_METER_MODE:        meter_mode_r   <= cfg_data[0];
        trtbm_pkg::REG_FIRST_INFO_RATE:   first_rate_r   <= cfg_data;
        trtbm_pkg::REG_FIRST_BURST_SIZE:  first_burst_r  <= cfg_data;
        trtbm_pkg::REG_SECOND_INFO_RATE:  second_rate_r  <= cfg_data;
        trtbm_pkg::REG_SECOND_BURST_SIZE: second_burst_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Stage readiness: a stage takes a beat when empty or when its contents move on
  assign rdy_out      = !out_valid_r || out_ch.ready;
  assign rdy3         = !v3_r || rdy_out;
  assign rdy2         = !v2_r || rdy3;
  assign rdy1         = !v1_r || rdy2;
  assign in_ch.ready  = rdy1;
  assign move3        = v3_r && rdy_out;

  // Stage 1: register the input beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (rdy1) begin
      v1_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_ch.valid) begin
      ts1_r  <= in_ch.timestamp;
      len1_r <= in_ch.packet_length;
    end
  end

  // Stage 2: partial products of timestamp times each rate
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (rdy2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      p1lo_r <= trtbm_pkg::PLO_W'(ts1_r[trtbm_pkg::TS_LO_W-1:0]) *
                trtbm_pkg::PLO_W'(first_rate_r);
      p1hi_r <= trtbm_pkg::PHI_W'(ts1_r[trtbm_pkg::TS_W-1:trtbm_pkg::TS_LO_W]) *
                trtbm_pkg::PHI_W'(first_rate_r);
      p2lo_r <= trtbm_pkg::PLO_W'(ts1_r[trtbm_pkg::TS_LO_W-1:0]) *
                trtbm_pkg::PLO_W'(second_rate_r);
      p2hi_r <= trtbm_pkg::PHI_W'(ts1_r[trtbm_pkg::TS_W-1:trtbm_pkg::TS_LO_W]) *
                trtbm_pkg::PHI_W'(second_rate_r);
      len2_r <= len1_r;
    end
  end

  // Stage 3: combine partial products, drop the rate fraction, keep 64 bits
  always_comb begin
    full1 = (trtbm_pkg::PROD_W'(p1hi_r) << trtbm_pkg::TS_LO_W) + trtbm_pkg::PROD_W'(p1lo_r);
    full2 = (trtbm_pkg::PROD_W'(p2hi_r) << trtbm_pkg::TS_LO_W) + trtbm_pkg::PROD_W'(p2lo_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (rdy3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      earn1_r <= full1[trtbm_pkg::RATE_FRAC_BITS +: trtbm_pkg::EARN_W];
      earn2_r <= full2[trtbm_pkg::RATE_FRAC_BITS +: trtbm_pkg::EARN_W];
      len3_r  <= len2_r;
    end
  end

  // Bucket checks: the second bucket only advances when the first passes
  assign cost3       = meter_mode_r ? trtbm_pkg::PACKET_COST : len3_r;
  assign ctl1.check  = move3 && meter_enable_r;
  assign ctl1.refill = cfg_we && (cfg_index == trtbm_pkg::REG_FIRST_BURST_SIZE);
  assign ctl2.check  = move3 && meter_enable_r && pass1;
  assign ctl2.refill = cfg_we && (cfg_index == trtbm_pkg::REG_SECOND_BURST_SIZE);

  trtbm_bucket u_first (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl1),
    .burst        (first_burst_r),
    .refill_value (cfg_data),
    .now_earned   (earn1_r),
    .cost         (cost3),
    .pass         (pass1)
  );

  trtbm_bucket u_second (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl2),
    .burst        (second_burst_r),
    .refill_value (cfg_data),
    .now_earned   (earn2_r),
    .cost         (cost3),
    .pass         (pass2)
  );

  // Pick the color
  always_comb begin
    if (!meter_enable_r) begin
      color_nxt = trtbm_pkg::COLOR_CONFORM;
    end else if (!pass1) begin
      color_nxt = trtbm_pkg::COLOR_EXCEED_FIRST;
    end else if (!pass2) begin
      color_nxt = trtbm_pkg::COLOR_EXCEED_SECOND;
    end else begin
      color_nxt = trtbm_pkg::COLOR_CONFORM;
    end
  end

  // Result register: hold until the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rdy_out) begin
      out_valid_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (move3) begin
      color_r <= color_nxt;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.color = color_r;

endmodule
